// ===== hw/rtl/distance_vector_route_table_macros.svh =====
// Assertion macros used by the route table checker.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_MACROS_SVH

// Property checked on every rising edge outside reset.
`define DVRT_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define DVRT_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/dvrt_pkg.sv =====
// Types, sizes and codes of the distance-vector route table.
package dvrt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int NUM_PORTS     = 4;
    localparam int MAX_RESULTS   = 64;

    localparam int ID_W     = 8;
    localparam int COST_W   = 16;
    localparam int PORT_W   = 2;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    localparam int TBL_IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int TBL_CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int PORT_CNT_W = $clog2(NUM_PORTS + 1);
    localparam int PORT_EXT_W = (PORT_IDX_W > PORT_W) ? PORT_IDX_W : PORT_W;
    localparam int RES_CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int PROD_W     = TBL_CNT_W + PORT_CNT_W;
    localparam int CMP_W      = (PROD_W > RES_CNT_W) ? PROD_W : RES_CNT_W;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_ADVERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BIND   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_SELF    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NO_GAIN = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]       dest;
        logic [COST_W-1:0]     cost;
        logic [PORT_IDX_W-1:0] nport;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_BC_START,
        S_BC_READ,
        S_BC_EMIT,
        S_STATUS
    } state_t;

endpackage

// ===== hw/rtl/distance_vector_route_table.sv =====
// Distance-vector route table: search, update and broadcast over one table memory.
//
//  channel   direction  handshake               payload
//  cfg       in         cfg_wr_en               cfg_wr_data (self_id)
//  msg       in         msg_valid / msg_stall   kind, port, dest_id, cost_in
//  res       out        res_valid / res_stall   is_advert, out_port, out_dest,
//                                               out_cost, status, last
//
// One message at a time. Every table lookup sweeps the memory once.
// A broadcast walks up to NUM_PORTS * TABLE_ENTRIES slots, port by port, and stops
// after the last advertisement; the table has a single read port, so each slot is
// read before its advertisement is sent, and the next slot waits for that send.
// Reset clears the state and the valid-entry count at once; there is no clearing pass.
// msg_stall stays high from acceptance until the final beat is loaded into the output
// register; a stalled output holds the walk.
module distance_vector_route_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [dvrt_pkg::ID_W-1:0]      cfg_wr_data,
    input  logic                           msg_valid,
    output logic                           msg_stall,
    input  logic [dvrt_pkg::KIND_W-1:0]    kind,
    input  logic [dvrt_pkg::PORT_W-1:0]    port,
    input  logic [dvrt_pkg::ID_W-1:0]      dest_id,
    input  logic [dvrt_pkg::COST_W-1:0]    cost_in,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic                           is_advert,
    output logic [dvrt_pkg::PORT_W-1:0]    out_port,
    output logic [dvrt_pkg::ID_W-1:0]      out_dest,
    output logic [dvrt_pkg::COST_W-1:0]    out_cost,
    output logic [dvrt_pkg::STATUS_W-1:0]  status,
    output logic                           last
);

    localparam int TBL_IDX_W  = dvrt_pkg::TBL_IDX_W;
    localparam int TBL_CNT_W  = dvrt_pkg::TBL_CNT_W;
    localparam int PORT_IDX_W = dvrt_pkg::PORT_IDX_W;
    localparam int PORT_CNT_W = dvrt_pkg::PORT_CNT_W;
    localparam int PORT_EXT_W = dvrt_pkg::PORT_EXT_W;
    localparam int RES_CNT_W  = dvrt_pkg::RES_CNT_W;
    localparam int CMP_W      = dvrt_pkg::CMP_W;
    localparam int ID_W       = dvrt_pkg::ID_W;
    localparam int COST_W     = dvrt_pkg::COST_W;

    // Table memory and its read data
    dvrt_pkg::entry_t tbl_mem [dvrt_pkg::TABLE_ENTRIES];
    dvrt_pkg::entry_t rd_data_reg;

    dvrt_pkg::state_t state_reg, state_next;

    logic [ID_W-1:0]       self_id_reg;
    logic                  port_bound_reg [dvrt_pkg::NUM_PORTS];
    logic [ID_W-1:0]       port_nbr_reg   [dvrt_pkg::NUM_PORTS];
    logic [PORT_CNT_W-1:0] bound_cnt_reg;
    logic [TBL_CNT_W-1:0]  valid_cnt_reg;

    logic [dvrt_pkg::KIND_W-1:0] req_kind_reg;
    logic [PORT_IDX_W-1:0]       req_port_reg;
    logic [ID_W-1:0]             req_dest_reg;
    logic [COST_W-1:0]           req_cost_reg;
    logic [ID_W-1:0]             nbr_id_reg;
    logic [PORT_IDX_W-1:0]       link_port_reg;

    logic [TBL_CNT_W-1:0] srch_cnt_reg;
    logic                 hit_a_reg, hit_b_reg;
    logic [TBL_IDX_W-1:0] idx_a_reg;
    logic [COST_W-1:0]    cost_a_reg, cost_b_reg;

    logic [dvrt_pkg::STATUS_W-1:0] status_reg;

    logic [PORT_CNT_W-1:0] bc_port_reg;
    logic [TBL_CNT_W-1:0]  bc_ent_reg;
    logic [RES_CNT_W-1:0]  bc_total_reg, bc_sent_reg;

    logic                          res_valid_reg;
    logic                          is_advert_reg;
    logic [dvrt_pkg::PORT_W-1:0]   out_port_reg;
    logic [ID_W-1:0]               out_dest_reg;
    logic [COST_W-1:0]             out_cost_reg;
    logic [dvrt_pkg::STATUS_W-1:0] status_out_reg;
    logic                          last_reg;

    // Message decode
    logic [PORT_EXT_W-1:0] port_ext;
    logic [PORT_IDX_W-1:0] port_sel;
    logic                  port_ok;
    logic                  rem_hit;
    logic [PORT_IDX_W-1:0] rem_port;
    dvrt_pkg::state_t      idle_next;
    logic [dvrt_pkg::STATUS_W-1:0] idle_status;
    logic                  idle_bind;
    logic                  msg_acc;

    // Search and decision
    logic [TBL_CNT_W-1:0]  prev_idx;
    logic                  prev_valid;
    logic                  match_a, match_b;
    logic                  srch_done;
    logic [COST_W:0]       cost_sum;
    logic [COST_W-1:0]     cost_sat;
    logic                  tbl_full;
    dvrt_pkg::state_t      dec_next;
    logic [dvrt_pkg::STATUS_W-1:0] dec_status;
    logic                  dec_wr;
    logic [TBL_IDX_W-1:0]  dec_wr_addr;
    dvrt_pkg::entry_t      dec_wr_data;
    logic                  dec_insert;

    // Broadcast walk
    logic [CMP_W-1:0]      bc_prod;
    logic [RES_CNT_W-1:0]  bc_total_now;
    logic                  bc_hit;
    logic                  bc_last;
    logic                  bc_step;
    logic                  out_free;
    logic                  load_advert;
    logic                  load_status;

    // Memory ports
    logic                  mem_rd_en;
    logic [TBL_IDX_W-1:0]  mem_rd_addr;
    logic                  mem_wr_en;
    logic [TBL_IDX_W-1:0]  mem_wr_addr;
    dvrt_pkg::entry_t      mem_wr_data;

    assign port_ext = PORT_EXT_W'(port);
    assign port_sel = port_ext[PORT_IDX_W-1:0];
    assign port_ok  = ({1'b0, port_ext} < (PORT_EXT_W + 1)'(dvrt_pkg::NUM_PORTS));
    assign msg_acc  = msg_valid && (state_reg == dvrt_pkg::S_IDLE);
    assign out_free = !res_valid_reg || !res_stall;

    // Highest bound port whose neighbor matches the message
    always_comb
    begin
        rem_hit  = 1'b0;
        rem_port = '0;
        for (int p = 0; p < dvrt_pkg::NUM_PORTS; p++)
        begin
            if (port_bound_reg[p] && (port_nbr_reg[p] == dest_id))
            begin
                rem_hit  = 1'b1;
                rem_port = PORT_IDX_W'(p);
            end
        end
    end

    always_comb
    begin
        idle_next   = dvrt_pkg::S_IDLE;
        idle_status = dvrt_pkg::STAT_OK;
        idle_bind   = 1'b0;
        if (msg_valid)
        begin
            case (kind)
                dvrt_pkg::KIND_TICK:
                begin
                    idle_next = dvrt_pkg::S_BC_START;
                end
                dvrt_pkg::KIND_ADVERT:
                begin
                    if (dest_id == self_id_reg)
                    begin
                        idle_next   = dvrt_pkg::S_STATUS;
                        idle_status = dvrt_pkg::STAT_SELF;
                    end
                    else if (!port_ok || !port_bound_reg[port_sel])
                    begin
                        idle_next   = dvrt_pkg::S_STATUS;
                        idle_status = dvrt_pkg::STAT_UNKNOWN;
                    end
                    else
                    begin
                        idle_next = dvrt_pkg::S_SEARCH;
                    end
                end
                dvrt_pkg::KIND_LINK:
                begin
                    if (dest_id == self_id_reg)
                    begin
                        idle_next   = dvrt_pkg::S_STATUS;
                        idle_status = dvrt_pkg::STAT_SELF;
                    end
                    else if (!rem_hit)
                    begin
                        idle_next   = dvrt_pkg::S_STATUS;
                        idle_status = dvrt_pkg::STAT_UNKNOWN;
                    end
                    else
                    begin
                        idle_next = dvrt_pkg::S_SEARCH;
                    end
                end
                default:
                begin
                    if (dest_id == self_id_reg)
                    begin
                        idle_next   = dvrt_pkg::S_STATUS;
                        idle_status = dvrt_pkg::STAT_SELF;
                    end
                    else if (!port_ok)
                    begin
                        idle_next   = dvrt_pkg::S_STATUS;
                        idle_status = dvrt_pkg::STAT_UNKNOWN;
                    end
                    else
                    begin
                        idle_next = dvrt_pkg::S_SEARCH;
                        idle_bind = 1'b1;
                    end
                end
            endcase
        end
    end

    // Read data of a sweep step belongs to the slot issued in the previous cycle
    assign prev_idx   = srch_cnt_reg - TBL_CNT_W'(1);
    assign prev_valid = (state_reg == dvrt_pkg::S_SEARCH) && (srch_cnt_reg != '0)
                        && (prev_idx < valid_cnt_reg);
    assign match_a    = prev_valid && !hit_a_reg && (rd_data_reg.dest == req_dest_reg);
    assign match_b    = prev_valid && !hit_b_reg && (rd_data_reg.dest == nbr_id_reg);
    assign srch_done  = (srch_cnt_reg == TBL_CNT_W'(dvrt_pkg::TABLE_ENTRIES));

    assign cost_sum = {1'b0, req_cost_reg} + {1'b0, cost_b_reg};
    assign cost_sat = cost_sum[COST_W] ? dvrt_pkg::COST_MAX : cost_sum[COST_W-1:0];
    assign tbl_full = (valid_cnt_reg == TBL_CNT_W'(dvrt_pkg::TABLE_ENTRIES));

    always_comb
    begin
        dec_next    = dvrt_pkg::S_STATUS;
        dec_status  = dvrt_pkg::STAT_OK;
        dec_wr      = 1'b0;
        dec_wr_addr = idx_a_reg;
        dec_insert  = 1'b0;
        dec_wr_data = '{dest: req_dest_reg, cost: req_cost_reg, nport: req_port_reg};
        case (req_kind_reg)
            dvrt_pkg::KIND_ADVERT:
            begin
                dec_wr_data.cost = cost_sat;
                if (!hit_b_reg)
                begin
                    dec_status = dvrt_pkg::STAT_UNKNOWN;
                end
                else if (hit_a_reg)
                begin
                    if (cost_sat < cost_a_reg)
                    begin
                        dec_wr   = 1'b1;
                        dec_next = dvrt_pkg::S_BC_START;
                    end
                    else
                    begin
                        dec_status = dvrt_pkg::STAT_NO_GAIN;
                    end
                end
                else if (tbl_full)
                begin
                    dec_status = dvrt_pkg::STAT_FULL;
                end
                else
                begin
                    dec_wr      = 1'b1;
                    dec_insert  = 1'b1;
                    dec_wr_addr = valid_cnt_reg[TBL_IDX_W-1:0];
                end
            end
            dvrt_pkg::KIND_LINK:
            begin
                dec_wr_data.nport = link_port_reg;
                if (!hit_a_reg)
                begin
                    dec_status = dvrt_pkg::STAT_UNKNOWN;
                end
                else
                begin
                    dec_wr   = 1'b1;
                    dec_next = dvrt_pkg::S_BC_START;
                end
            end
            default:
            begin
                if (hit_a_reg)
                begin
                    dec_wr = 1'b1;
                end
                else if (tbl_full)
                begin
                    dec_status = dvrt_pkg::STAT_FULL;
                end
                else
                begin
                    dec_wr      = 1'b1;
                    dec_insert  = 1'b1;
                    dec_wr_addr = valid_cnt_reg[TBL_IDX_W-1:0];
                end
            end
        endcase
    end

    // Walk length: every valid entry on every bound port, capped
    assign bc_prod = CMP_W'(bound_cnt_reg) * CMP_W'(valid_cnt_reg);
    assign bc_total_now = (bc_prod > CMP_W'(dvrt_pkg::MAX_RESULTS))
                          ? RES_CNT_W'(dvrt_pkg::MAX_RESULTS) : RES_CNT_W'(bc_prod);
    assign bc_hit  = port_bound_reg[bc_port_reg[PORT_IDX_W-1:0]]
                     && (bc_ent_reg < valid_cnt_reg);
    assign bc_last = (bc_sent_reg == (bc_total_reg - RES_CNT_W'(1)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dvrt_pkg::S_IDLE:     state_next = idle_next;
            dvrt_pkg::S_SEARCH:
            begin
                if (srch_done)
                begin
                    state_next = dvrt_pkg::S_DECIDE;
                end
            end
            dvrt_pkg::S_DECIDE:   state_next = dec_next;
            dvrt_pkg::S_BC_START:
            begin
                state_next = (bc_total_now == '0) ? dvrt_pkg::S_STATUS : dvrt_pkg::S_BC_READ;
            end
            dvrt_pkg::S_BC_READ:
            begin
                if (bc_hit)
                begin
                    state_next = dvrt_pkg::S_BC_EMIT;
                end
            end
            dvrt_pkg::S_BC_EMIT:
            begin
                if (out_free)
                begin
                    state_next = bc_last ? dvrt_pkg::S_IDLE : dvrt_pkg::S_BC_READ;
                end
            end
            dvrt_pkg::S_STATUS:
            begin
                if (out_free)
                begin
                    state_next = dvrt_pkg::S_IDLE;
                end
            end
            default:              state_next = dvrt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        msg_stall   = 1'b1;
        mem_rd_en   = 1'b0;
        mem_rd_addr = srch_cnt_reg[TBL_IDX_W-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = dec_wr_addr;
        mem_wr_data = dec_wr_data;
        bc_step     = 1'b0;
        load_advert = 1'b0;
        load_status = 1'b0;
        case (state_reg)
            dvrt_pkg::S_IDLE:
            begin
                msg_stall = 1'b0;
            end
            dvrt_pkg::S_SEARCH:
            begin
                mem_rd_en = !srch_done;
            end
            dvrt_pkg::S_DECIDE:
            begin
                mem_wr_en = dec_wr;
            end
            dvrt_pkg::S_BC_READ:
            begin
                mem_rd_en   = bc_hit;
                mem_rd_addr = bc_ent_reg[TBL_IDX_W-1:0];
                bc_step     = !bc_hit;
            end
            dvrt_pkg::S_BC_EMIT:
            begin
                load_advert = out_free;
                bc_step     = out_free;
            end
            dvrt_pkg::S_STATUS:
            begin
                load_status = out_free;
            end
            default:
            begin
                msg_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dvrt_pkg::S_IDLE;
            self_id_reg   <= '0;
            for (int p = 0; p < dvrt_pkg::NUM_PORTS; p++)
            begin
                port_bound_reg[p] <= 1'b0;
            end
            bound_cnt_reg <= '0;
            valid_cnt_reg <= '0;
            srch_cnt_reg  <= '0;
            hit_a_reg     <= 1'b0;
            hit_b_reg     <= 1'b0;
            bc_port_reg   <= '0;
            bc_ent_reg    <= '0;
            bc_total_reg  <= '0;
            bc_sent_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                self_id_reg <= cfg_wr_data;
            end
            if (msg_acc)
            begin
                srch_cnt_reg <= '0;
                hit_a_reg    <= 1'b0;
                hit_b_reg    <= 1'b0;
                if (idle_bind)
                begin
                    port_bound_reg[port_sel] <= 1'b1;
                    if (!port_bound_reg[port_sel])
                    begin
                        bound_cnt_reg <= bound_cnt_reg + PORT_CNT_W'(1);
                    end
                end
            end
            if ((state_reg == dvrt_pkg::S_SEARCH) && !srch_done)
            begin
                srch_cnt_reg <= srch_cnt_reg + TBL_CNT_W'(1);
            end
            if (match_a)
            begin
                hit_a_reg <= 1'b1;
            end
            if (match_b)
            begin
                hit_b_reg <= 1'b1;
            end
            if ((state_reg == dvrt_pkg::S_DECIDE) && dec_insert)
            begin
                valid_cnt_reg <= valid_cnt_reg + TBL_CNT_W'(1);
            end
            if (state_reg == dvrt_pkg::S_BC_START)
            begin
                bc_total_reg <= bc_total_now;
                bc_port_reg  <= '0;
                bc_ent_reg   <= '0;
                bc_sent_reg  <= '0;
            end
            if (bc_step)
            begin
                if (bc_ent_reg == TBL_CNT_W'(dvrt_pkg::TABLE_ENTRIES - 1))
                begin
                    bc_ent_reg  <= '0;
                    bc_port_reg <= bc_port_reg + PORT_CNT_W'(1);
                end
                else
                begin
                    bc_ent_reg <= bc_ent_reg + TBL_CNT_W'(1);
                end
            end
            if (load_advert)
            begin
                bc_sent_reg <= bc_sent_reg + RES_CNT_W'(1);
            end
            if (load_advert || load_status)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (msg_acc)
        begin
            req_kind_reg  <= kind;
            req_port_reg  <= port_sel;
            req_dest_reg  <= dest_id;
            req_cost_reg  <= cost_in;
            nbr_id_reg    <= port_nbr_reg[port_sel];
            link_port_reg <= rem_port;
            status_reg    <= idle_status;
            if (idle_bind)
            begin
                port_nbr_reg[port_sel] <= dest_id;
            end
        end
        if (match_a)
        begin
            idx_a_reg  <= prev_idx[TBL_IDX_W-1:0];
            cost_a_reg <= rd_data_reg.cost;
        end
        if (match_b)
        begin
            cost_b_reg <= rd_data_reg.cost;
        end
        if (state_reg == dvrt_pkg::S_DECIDE)
        begin
            status_reg <= dec_status;
        end
        if (state_reg == dvrt_pkg::S_BC_START)
        begin
            status_reg <= dvrt_pkg::STAT_OK;
        end
        if (load_advert)
        begin
            is_advert_reg  <= 1'b1;
            out_port_reg   <= dvrt_pkg::PORT_W'(bc_port_reg);
            out_dest_reg   <= rd_data_reg.dest;
            out_cost_reg   <= rd_data_reg.cost;
            status_out_reg <= dvrt_pkg::STAT_OK;
            last_reg       <= bc_last;
        end
        else if (load_status)
        begin
            is_advert_reg  <= 1'b0;
            out_port_reg   <= '0;
            out_dest_reg   <= '0;
            out_cost_reg   <= '0;
            status_out_reg <= status_reg;
            last_reg       <= 1'b1;
        end
    end

    // Writes and reads never target the same cycle: the sequencer keeps them apart
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            tbl_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= tbl_mem[mem_rd_addr];
        end
    end

    assign res_valid = res_valid_reg;
    assign is_advert = is_advert_reg;
    assign out_port  = out_port_reg;
    assign out_dest  = out_dest_reg;
    assign out_cost  = out_cost_reg;
    assign status    = status_out_reg;
    assign last      = last_reg;

endmodule

// ===== hw/rtl/dvrt_checker.sv =====
// Port-level checker of the route table, bound to the top level.
`include "distance_vector_route_table_macros.svh"

module dvrt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           msg_valid,
    input logic                           msg_stall,
    input logic                           res_valid,
    input logic                           res_stall,
    input logic                           is_advert,
    input logic [dvrt_pkg::PORT_W-1:0]    out_port,
    input logic [dvrt_pkg::ID_W-1:0]      out_dest,
    input logic [dvrt_pkg::COST_W-1:0]    out_cost,
    input logic [dvrt_pkg::STATUS_W-1:0]  status,
    input logic                           last
);

    // Hold a stalled result beat
    `DVRT_ASSERT_CLK(a_res_hold, res_valid && res_stall |=> res_valid && $stable(out_cost) && $stable(out_dest) && $stable(last), "stalled result changed")

    // A message in flight blocks the next one
    `DVRT_ASSERT_CLK(a_busy_after_accept, msg_valid && !msg_stall |=> msg_stall, "accepted a second message while busy")

    `DVRT_ASSERT_NEVER(a_status_not_last, res_valid && !is_advert && !last, "status-only result not marked last")

    `DVRT_ASSERT_NEVER(a_advert_status, res_valid && is_advert && (status != dvrt_pkg::STAT_OK), "advertisement with non-ok status")

    `DVRT_ASSERT_CLK(a_status_zero_payload, res_valid && !is_advert |-> (out_port == '0) && (out_dest == '0) && (out_cost == '0), "status-only result with payload")

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (.*);
